@@ design/rcm_pkg.sv @@
// Shared types, constants and width helpers for the three-input channel mixer.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package rcm_pkg;

   localparam int FRACTION_BITS = 14;

   localparam int VALUE_W     = 16;
   localparam int WEIGHT_W    = 8;
   localparam int THRESH_W    = 7;
   localparam int CTL_W       = 3;
   localparam int PULSE_W     = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam int PERCENT    = 100;
   localparam int PULSE_MIN  = 1000;
   localparam int PULSE_MID  = 1500;
   localparam int PULSE_MAX  = 2000;
   localparam int PULSE_SPAN = 500;

   // channel_control bit positions
   localparam int CTL_ENABLE   = 0;
   localparam int CTL_MULTIPLY = 1;
   localparam int CTL_INVERT   = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WEIGHT_A,
      CSR_WEIGHT_B,
      CSR_WEIGHT_C,
      CSR_OFFSET_A,
      CSR_OFFSET_B,
      CSR_OFFSET_C,
      CSR_SWITCH_THRESHOLD,
      CSR_CHANNEL_CONTROL
   } csr_index_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_a;
      logic                      present_a;
      logic signed [VALUE_W-1:0] value_b;
      logic                      present_b;
      logic signed [VALUE_W-1:0] value_c;
      logic                      present_c;
   } rcm_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] mixed_signal;
      logic [PULSE_W-1:0]        pulse_us;
      logic                      switch_on;
   } rcm_rsp_type;

   // load enables for the three term stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   // signed width of one term: holds +-(32768 + ONE) with margin
   function automatic int term_width(input int f);
      return ((f > 15) ? f : 15) + 3;
   endfunction

   // signed width of value*weight + offset*ONE
   function automatic int num_width(input int f);
      return ((f > 15) ? f : 15) + 9;
   endfunction

endpackage

@@ design/rc_channel_mixer_unit.sv @@
// Throughput one request per cycle while the output is not stalled.
// Ten register stages: three per term, two per multiply-and-round step, clamp, pulse span product, pulse rounding.
// A stalled output holds each full stage with only full stages after it; empty stages still take new requests.
// Reset (synchronous) empties the pipeline and returns the configuration registers to their defaults.
// Top level of the channel mixer; instantiates rcm_term three times, uses rcm_pkg.
`timescale 1ns / 1ps

module rc_channel_mixer_unit #(
   parameter int FRACTION_BITS = rcm_pkg::FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rcm_pkg::rcm_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rcm_pkg::rcm_rsp_type                rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  rcm_pkg::csr_index_type              csr_index,
   input  logic [rcm_pkg::CSR_DATA_W-1:0]      csr_data
);
   import rcm_pkg::*;

   localparam int TW  = term_width(FRACTION_BITS);
   localparam int SUW = TW + 2;
   localparam int MW1 = 2 * TW;
   localparam int PW  = MW1 - FRACTION_BITS;
   localparam int MW2 = PW + TW;
   localparam int QW  = MW2 - FRACTION_BITS;
   localparam int SW  = FRACTION_BITS + 2;
   localparam int PRW = SW + 10;
   localparam int THW = FRACTION_BITS + 8;
   localparam int PLW = PULSE_W + 2;
   localparam int NSTAGE = 10;

   localparam longint ONE  = longint'(1) << FRACTION_BITS;
   localparam longint HALF = ONE >> 1;
   localparam logic signed [QW-1:0] ONE_Q = QW'(ONE);
   localparam logic signed [SW-1:0] ONE_S = SW'(ONE);
   localparam logic signed [WEIGHT_W-1:0] PCT_W = WEIGHT_W'(PERCENT);
   localparam logic [THRESH_W-1:0] PCT_T = THRESH_W'(PERCENT);

   // ---------------- configuration registers ----------------
   logic signed [WEIGHT_W-1:0] weight_ff [3];
   logic signed [WEIGHT_W-1:0] weight_in [3];
   logic signed [WEIGHT_W-1:0] offset_ff [3];
   logic signed [WEIGHT_W-1:0] offset_in [3];
   logic [THRESH_W-1:0]        thresh_ff, thresh_in;
   logic [CTL_W-1:0]           ctl_ff, ctl_in;
   logic signed [WEIGHT_W-1:0] csr_pct;
   logic [THRESH_W-1:0]        csr_thr;

   assign csr_ready = 1'b1;

   always_comb begin
      // saturate percentages on the way in
      if (signed'(csr_data) > PCT_W) begin
         csr_pct = PCT_W;
      end else if (signed'(csr_data) < -PCT_W) begin
         csr_pct = -PCT_W;
      end else begin
         csr_pct = signed'(csr_data);
      end
      csr_thr = (csr_data[THRESH_W-1:0] > PCT_T) ? PCT_T : csr_data[THRESH_W-1:0];

      weight_in = weight_ff;
      offset_in = offset_ff;
      thresh_in = thresh_ff;
      ctl_in    = ctl_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WEIGHT_A:         weight_in[0] = csr_pct;
            CSR_WEIGHT_B:         weight_in[1] = csr_pct;
            CSR_WEIGHT_C:         weight_in[2] = csr_pct;
            CSR_OFFSET_A:         offset_in[0] = csr_pct;
            CSR_OFFSET_B:         offset_in[1] = csr_pct;
            CSR_OFFSET_C:         offset_in[2] = csr_pct;
            CSR_SWITCH_THRESHOLD: thresh_in    = csr_thr;
            CSR_CHANNEL_CONTROL:  ctl_in       = csr_data[CTL_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '{PCT_W, '0, '0};
         offset_ff <= '{'0, '0, '0};
         thresh_ff <= THRESH_W'(PERCENT / 2);
         ctl_ff    <= '0;
      end else begin
         weight_ff <= weight_in;
         offset_ff <= offset_in;
         thresh_ff <= thresh_in;
         ctl_ff    <= ctl_in;
      end
   end

   // ---------------- pipeline control ----------------
   logic [NSTAGE:1] valid_ff, valid_in, adv;

   // a stage loads when it is empty or its content moves on
   always_comb begin
      adv[NSTAGE] = !valid_ff[NSTAGE] || rsp_ready;
      for (int k = NSTAGE - 1; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in = (adv & {valid_ff[NSTAGE-1:1], req_valid}) | (~adv & valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = adv[1];
   assign rsp_valid = valid_ff[NSTAGE];

   // ---------------- stages 1..3: terms ----------------
   stage_en_type          term_en;
   logic signed [TW-1:0]  term_a, term_b, term_c;
   logic                  act_a, act_b, act_c;

   assign term_en = '{s1: adv[1], s2: adv[2], s3: adv[3]};

   rcm_term #(.FRACTION_BITS(FRACTION_BITS)) u_term_a (
      .clock(clock), .en(term_en), .value(req_data.value_a), .present(req_data.present_a),
      .weight(weight_ff[0]), .offset(offset_ff[0]), .term(term_a), .active(act_a)
   );

   rcm_term #(.FRACTION_BITS(FRACTION_BITS)) u_term_b (
      .clock(clock), .en(term_en), .value(req_data.value_b), .present(req_data.present_b),
      .weight(weight_ff[1]), .offset(offset_ff[1]), .term(term_b), .active(act_b)
   );

   rcm_term #(.FRACTION_BITS(FRACTION_BITS)) u_term_c (
      .clock(clock), .en(term_en), .value(req_data.value_c), .present(req_data.present_c),
      .weight(weight_ff[2]), .offset(offset_ff[2]), .term(term_c), .active(act_c)
   );

   // ---------------- stage 4: sum, pack active terms, first multiply ----------------
   logic signed [TW-1:0]  x0_4, x1_4;
   logic signed [TW-1:0]  x0_4_ff, x2_4_ff;
   logic [1:0]            cnt4_in, cnt4_ff;
   logic signed [SUW-1:0] sum4_in, sum4_ff;
   logic signed [MW1-1:0] m4_in, m4_ff;

   always_comb begin
      sum4_in = SUW'(term_a) + SUW'(term_b) + SUW'(term_c);
      cnt4_in = 2'(act_a) + 2'(act_b) + 2'(act_c);
      // active terms in order a, b, c
      x0_4 = act_a ? term_a : (act_b ? term_b : term_c);
      x1_4 = (act_a && act_b) ? term_b : term_c;
      m4_in = MW1'(x0_4) * MW1'(x1_4);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         x0_4_ff <= x0_4;
         x2_4_ff <= term_c;
         cnt4_ff <= cnt4_in;
         sum4_ff <= sum4_in;
         m4_ff   <= m4_in;
      end
   end

   // ---------------- stage 5: rescale first product ----------------
   logic [MW1-1:0]        m4_mag;
   logic signed [PW-1:0]  m4_rnd;
   logic signed [PW-1:0]  p5_in, p5_ff;
   logic signed [TW-1:0]  x2_5_ff;
   logic [1:0]            cnt5_ff;
   logic signed [SUW-1:0] sum5_ff;

   always_comb begin
      m4_mag = (m4_ff[MW1-1] ? MW1'(-m4_ff) : MW1'(m4_ff)) + MW1'(HALF);
      m4_rnd = signed'(PW'(m4_mag >> FRACTION_BITS));
      if (cnt4_ff >= 2'd2) begin
         p5_in = m4_ff[MW1-1] ? -m4_rnd : m4_rnd;
      end else if (cnt4_ff == 2'd1) begin
         p5_in = PW'(x0_4_ff);
      end else begin
         p5_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         p5_ff   <= p5_in;
         x2_5_ff <= x2_4_ff;
         cnt5_ff <= cnt4_ff;
         sum5_ff <= sum4_ff;
      end
   end

   // ---------------- stage 6: second multiply ----------------
   logic signed [MW2-1:0] m6_in, m6_ff;
   logic signed [PW-1:0]  p6_ff;
   logic [1:0]            cnt6_ff;
   logic signed [SUW-1:0] sum6_ff;

   assign m6_in = MW2'(p5_ff) * MW2'(x2_5_ff);

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         m6_ff   <= m6_in;
         p6_ff   <= p5_ff;
         cnt6_ff <= cnt5_ff;
         sum6_ff <= sum5_ff;
      end
   end

   // ---------------- stage 7: rescale second product ----------------
   logic [MW2-1:0]        m6_mag;
   logic signed [QW-1:0]  m6_rnd;
   logic signed [QW-1:0]  p7_in, p7_ff;
   logic signed [SUW-1:0] sum7_ff;

   always_comb begin
      m6_mag = (m6_ff[MW2-1] ? MW2'(-m6_ff) : MW2'(m6_ff)) + MW2'(HALF);
      m6_rnd = signed'(QW'(m6_mag >> FRACTION_BITS));
      if (cnt6_ff == 2'd3) begin
         p7_in = m6_ff[MW2-1] ? -m6_rnd : m6_rnd;
      end else begin
         p7_in = QW'(p6_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         p7_ff   <= p7_in;
         sum7_ff <= sum6_ff;
      end
   end

   // ---------------- stage 8: mode select, saturate, invert ----------------
   logic signed [QW-1:0] pick8, clip8;
   logic signed [SW-1:0] sig8_in, sig8_ff;

   always_comb begin
      pick8 = ctl_ff[CTL_MULTIPLY] ? p7_ff : QW'(sum7_ff);
      if (pick8 > ONE_Q) begin
         clip8 = ONE_Q;
      end else if (pick8 < -ONE_Q) begin
         clip8 = -ONE_Q;
      end else begin
         clip8 = pick8;
      end
      if (!ctl_ff[CTL_ENABLE]) begin
         sig8_in = '0;
      end else if (ctl_ff[CTL_INVERT]) begin
         sig8_in = SW'(-clip8);
      end else begin
         sig8_in = SW'(clip8);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         sig8_ff <= sig8_in;
      end
   end

   // ---------------- stage 9: pulse span product, switch compare ----------------
   logic [SW-1:0]         mag8;
   logic signed [PRW-1:0] span9_in, span9_ff;
   logic                  switch9_in, switch9_ff;
   logic signed [SW-1:0]  sig9_ff;

   always_comb begin
      mag8       = sig8_ff[SW-1] ? SW'(-sig8_ff) : SW'(sig8_ff);
      span9_in   = PRW'(sig8_ff) * PRW'(PULSE_SPAN);
      switch9_in = (THW'(mag8) * THW'(PERCENT)) >= (THW'(thresh_ff) << FRACTION_BITS);
   end

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         span9_ff   <= span9_in;
         switch9_ff <= switch9_in;
         sig9_ff    <= sig8_ff;
      end
   end

   // ---------------- stage 10: pulse rounding, output register ----------------
   logic [PRW-1:0]        span_mag;
   logic signed [PLW-1:0] step10, pulse10;
   rcm_rsp_type           rsp_in, rsp_ff;

   always_comb begin
      span_mag = ((span9_ff[PRW-1] ? PRW'(-span9_ff) : PRW'(span9_ff)) + PRW'(HALF))
                 >> FRACTION_BITS;
      step10   = signed'(PLW'(span_mag));
      pulse10  = PLW'(PULSE_MID) + (span9_ff[PRW-1] ? -step10 : step10);
      if (pulse10 < PLW'(PULSE_MIN)) begin
         pulse10 = PLW'(PULSE_MIN);
      end else if (pulse10 > PLW'(PULSE_MAX)) begin
         pulse10 = PLW'(PULSE_MAX);
      end
      rsp_in.mixed_signal = VALUE_W'(sig9_ff);
      rsp_in.pulse_us     = PULSE_W'(pulse10);
      rsp_in.switch_on    = switch9_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[10]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // ---------------- assertions ----------------
   // input held back only when every stage holds a request
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff))
      else $error("input stalled with an empty stage");

   a_sig_bound : assert property (@(posedge clock) disable iff (reset)
      valid_ff[8] |-> (sig8_ff <= ONE_S) && (sig8_ff >= -ONE_S))
      else $error("saturated signal out of range");

   a_no_terms : assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] && (cnt5_ff == 2'd0) |-> (p5_ff == '0))
      else $error("product without active terms is not zero");

   a_pulse_range : assert property (@(posedge clock) disable iff (reset)
      valid_ff[NSTAGE] |-> (rsp_ff.pulse_us >= PULSE_W'(PULSE_MIN))
                        && (rsp_ff.pulse_us <= PULSE_W'(PULSE_MAX)))
      else $error("pulse width out of range");

   a_disabled_zero : assert property (@(posedge clock) disable iff (reset)
      adv[8] && valid_ff[7] && !ctl_ff[CTL_ENABLE] |=> (sig8_ff == '0))
      else $error("disabled channel gave a nonzero signal");

endmodule

@@ design/rcm_term.sv @@
// One mixer term: (value*weight + offset*ONE)/100, rounded half away from zero.
// Three register stages: product and offset, reciprocal multiply, correction. Uses rcm_pkg.
`timescale 1ns / 1ps

module rcm_term #(
   parameter int FRACTION_BITS = rcm_pkg::FRACTION_BITS
) (
   input  logic                                                 clock,
   input  rcm_pkg::stage_en_type                                en,
   input  logic signed [rcm_pkg::VALUE_W-1:0]                   value,
   input  logic                                                 present,
   input  logic signed [rcm_pkg::WEIGHT_W-1:0]                  weight,
   input  logic signed [rcm_pkg::WEIGHT_W-1:0]                  offset,
   output logic signed [rcm_pkg::term_width(FRACTION_BITS)-1:0] term,
   output logic                                                 active
);
   import rcm_pkg::*;

   localparam int NW = num_width(FRACTION_BITS);
   localparam int TW = term_width(FRACTION_BITS);
   localparam int RW = NW - 6;
   localparam int VW = VALUE_W + WEIGHT_W;
   localparam logic [RW-1:0] RECIP    = RW'((64'd1 << NW) / 64'd100);
   localparam logic [NW-1:0] HALF_PCT = NW'(PERCENT / 2);
   localparam logic [NW-1:0] PCT      = NW'(PERCENT);

   logic signed [VALUE_W-1:0] v_sel;
   logic signed [VW-1:0]      vw;
   logic signed [NW-1:0]      n1_in, n1_ff;
   logic                      act1_in, act1_ff;

   logic [NW-1:0]             a2_in, a2_ff;
   logic [NW+RW-1:0]          prod2_in, prod2_ff;
   logic                      neg2_in, neg2_ff;
   logic                      act2_ff;

   logic [NW-1:0]             q3, rem3, qc3;
   logic signed [TW-1:0]      mag3;
   logic signed [TW-1:0]      term3_in, term3_ff;
   logic                      act3_ff;

   // stage 1: weighted value plus scaled offset
   always_comb begin
      v_sel   = present ? value : '0;
      vw      = VW'(v_sel) * VW'(weight);
      n1_in   = NW'(vw) + (NW'(offset) <<< FRACTION_BITS);
      act1_in = present || (offset != '0);
   end

   // stage 2: magnitude plus half, times floor(2^NW/100)
   always_comb begin
      neg2_in  = n1_ff[NW-1];
      a2_in    = (n1_ff[NW-1] ? NW'(-n1_ff) : NW'(n1_ff)) + HALF_PCT;
      prod2_in = (NW+RW)'(a2_in) * (NW+RW)'(RECIP);
   end

   // stage 3: estimate is low by at most one; fix up and restore the sign
   always_comb begin
      q3       = NW'(prod2_ff[NW+RW-1:NW]);
      rem3     = a2_ff - q3 * PCT;
      qc3      = (rem3 >= PCT) ? q3 + NW'(1) : q3;
      mag3     = signed'(TW'(qc3));
      term3_in = neg2_ff ? -mag3 : mag3;
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         n1_ff   <= n1_in;
         act1_ff <= act1_in;
      end
      if (en.s2) begin
         a2_ff    <= a2_in;
         prod2_ff <= prod2_in;
         neg2_ff  <= neg2_in;
         act2_ff  <= act1_ff;
      end
      if (en.s3) begin
         term3_ff <= term3_in;
         act3_ff  <= act2_ff;
      end
   end

   assign term   = term3_ff;
   assign active = act3_ff;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for rc_channel_mixer_unit: directed and random requests, a
// cycle-free predictor of the mix, pulse and switch outputs, and a result checker.
// Depends on rcm_pkg and the design sources only.
`timescale 1ns / 1ps

module testbench;
   import rcm_pkg::*;

   localparam longint UNITY        = longint'(1) << FRACTION_BITS;
   localparam int     PIPE_LATENCY = 10;
   localparam int     LONG_HOLD    = 120;
   localparam int     RANDOM_PHASES = 10;
   localparam int     PHASE_ITEMS  = 50;
   localparam longint TIMEOUT_NS   = 3_000_000;

   localparam logic signed [VALUE_W-1:0] FULL_SCALE = VALUE_W'(UNITY);
   localparam logic [CSR_DATA_W-1:0]     PCT_FULL   = CSR_DATA_W'(PERCENT);

   localparam logic [CSR_DATA_W-1:0] MODE_OFF   = '0;
   localparam logic [CSR_DATA_W-1:0] MODE_ADD   = CSR_DATA_W'(1) << CTL_ENABLE;
   localparam logic [CSR_DATA_W-1:0] MODE_MUL   = MODE_ADD | (CSR_DATA_W'(1) << CTL_MULTIPLY);
   localparam logic [CSR_DATA_W-1:0] INVERT_BIT = CSR_DATA_W'(1) << CTL_INVERT;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   rcm_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rcm_rsp_type           rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // channel settings as the block should hold them
   logic signed [WEIGHT_W-1:0] weight_pct [3];
   logic signed [WEIGHT_W-1:0] offset_pct [3];
   logic [THRESH_W-1:0]        threshold_pct;
   logic [CTL_W-1:0]           control_bits;

   rcm_rsp_type expected_mix_q [$];
   int          error_count    = 0;
   int          request_count  = 0;
   int          result_count   = 0;
   int          setting_count  = 0;
   bit          sender_idling  = 1'b0;
   bit          receiver_idling = 1'b0;
   bit          hold_off_request = 1'b0;

   rc_channel_mixer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // nearest, ties away from zero
   function automatic longint round_div(input longint n, input longint d);
      longint mag_n;
      longint q;
      mag_n = (n < 0) ? -n : n;
      q = (mag_n + d / 2) / d;
      return (n < 0) ? -q : q;
   endfunction

   function automatic rcm_rsp_type mix_channel(input rcm_req_type item);
      longint      src [3];
      logic        present [3];
      longint      term [3];
      logic        active [3];
      longint      gain, bias, sig, prod, pulse, thr, mag;
      logic        any_active;
      int          k;
      rcm_rsp_type res;
      present[0] = item.present_a;
      present[1] = item.present_b;
      present[2] = item.present_c;
      src[0] = longint'(item.value_a);
      src[1] = longint'(item.value_b);
      src[2] = longint'(item.value_c);
      for (k = 0; k < 3; k++) begin
         if (!present[k]) begin
            src[k] = 0;
         end
         gain = clamp(longint'(weight_pct[k]), -longint'(PERCENT), longint'(PERCENT));
         bias = clamp(longint'(offset_pct[k]), -longint'(PERCENT), longint'(PERCENT));
         term[k] = round_div(src[k] * gain + bias * UNITY, longint'(PERCENT));
         active[k] = present[k] || (bias != 0);
      end
      sig = 0;
      if (control_bits[CTL_ENABLE]) begin
         if (control_bits[CTL_MULTIPLY]) begin
            any_active = 1'b0;
            prod = 0;
            for (k = 0; k < 3; k++) begin
               if (active[k]) begin
                  prod = any_active ? round_div(prod * term[k], UNITY) : term[k];
                  any_active = 1'b1;
               end
            end
            sig = any_active ? prod : 0;
         end else begin
            sig = term[0] + term[1] + term[2];
         end
         sig = clamp(sig, -UNITY, UNITY);
         if (control_bits[CTL_INVERT]) begin
            sig = -sig;
         end
      end
      pulse = clamp(longint'(PULSE_MID) + round_div(sig * longint'(PULSE_SPAN), UNITY),
                    longint'(PULSE_MIN), longint'(PULSE_MAX));
      thr = (threshold_pct > PERCENT) ? longint'(PERCENT) : longint'(threshold_pct);
      mag = (sig < 0) ? -sig : sig;
      res.mixed_signal = sig[VALUE_W-1:0];
      res.pulse_us     = pulse[PULSE_W-1:0];
      res.switch_on    = (mag * longint'(PERCENT) >= thr * UNITY);
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   always @(posedge clock) begin : result_check
      rcm_rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         result_count++;
         if (expected_mix_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected (signal %0d)",
                                      rsp_data.mixed_signal));
         end else begin
            want = expected_mix_q.pop_front();
            if (rsp_data.mixed_signal !== want.mixed_signal) begin
               report_mismatch($sformatf("mixed_signal got %0d expected %0d",
                                         rsp_data.mixed_signal, want.mixed_signal));
            end
            if (rsp_data.pulse_us !== want.pulse_us) begin
               report_mismatch($sformatf("pulse_us got %0d expected %0d",
                                         rsp_data.pulse_us, want.pulse_us));
            end
            if (rsp_data.switch_on !== want.switch_on) begin
               report_mismatch($sformatf("switch_on got %b expected %b",
                                         rsp_data.switch_on, want.switch_on));
            end
         end
      end
   end

   // ---------------------------------------------------------------- result side

   initial begin : result_receiver
      int stall_left;
      int hold_left;
      bit hold_done;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- request side

   function automatic rcm_req_type make_request(
      input logic signed [VALUE_W-1:0] va, input logic pa,
      input logic signed [VALUE_W-1:0] vb, input logic pb,
      input logic signed [VALUE_W-1:0] vc, input logic pc);
      rcm_req_type r;
      r.value_a = va;  r.present_a = pa;
      r.value_b = vb;  r.present_b = pb;
      r.value_c = vc;  r.present_c = pc;
      return r;
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_source();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return VALUE_W'($urandom);
      end else if (pick == 1) begin
         case ($urandom_range(0, 4))
            0:       return FULL_SCALE;
            1:       return -FULL_SCALE;
            2:       return VALUE_W'(-32768);
            3:       return VALUE_W'(32767);
            default: return '0;
         endcase
      end
      return VALUE_W'(int'($urandom_range(0, int'(2 * UNITY))) - int'(UNITY));
   endfunction

   function automatic rcm_req_type random_request();
      return make_request(random_source(), $urandom_range(0, 3) != 0,
                          random_source(), $urandom_range(0, 3) != 0,
                          random_source(), $urandom_range(0, 3) != 0);
   endfunction

   // valid stays high on return; an idle gap lowers it at the next call
   task automatic send_request(input rcm_req_type item);
      int gap;
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      expected_mix_q.push_back(mix_channel(item));
      request_count++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (expected_mix_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_WEIGHT_A:         weight_pct[0] = value;
         CSR_WEIGHT_B:         weight_pct[1] = value;
         CSR_WEIGHT_C:         weight_pct[2] = value;
         CSR_OFFSET_A:         offset_pct[0] = value;
         CSR_OFFSET_B:         offset_pct[1] = value;
         CSR_OFFSET_C:         offset_pct[2] = value;
         CSR_SWITCH_THRESHOLD: threshold_pct = value[THRESH_W-1:0];
         CSR_CHANNEL_CONTROL:  control_bits  = value[CTL_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // drop requests, let the pipeline empty, then load every register
   task automatic apply_settings(
      input logic [CSR_DATA_W-1:0] wa, input logic [CSR_DATA_W-1:0] wb,
      input logic [CSR_DATA_W-1:0] wc, input logic [CSR_DATA_W-1:0] oa,
      input logic [CSR_DATA_W-1:0] ob, input logic [CSR_DATA_W-1:0] oc,
      input logic [CSR_DATA_W-1:0] thr, input logic [CSR_DATA_W-1:0] ctl);
      req_valid <= 1'b0;
      wait_drained();
      write_register(CSR_WEIGHT_A, wa);
      write_register(CSR_WEIGHT_B, wb);
      write_register(CSR_WEIGHT_C, wc);
      write_register(CSR_OFFSET_A, oa);
      write_register(CSR_OFFSET_B, ob);
      write_register(CSR_OFFSET_C, oc);
      write_register(CSR_SWITCH_THRESHOLD, thr);
      write_register(CSR_CHANNEL_CONTROL, ctl);
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_percent(input bit often_zero);
      int pick;
      pick = $urandom_range(0, 9);
      if (often_zero && pick < 4) begin
         return '0;
      end else if (pick == 9) begin
         return CSR_DATA_W'($urandom);
      end else if (pick == 8) begin
         return ($urandom_range(0, 1) != 0) ? PCT_FULL : -PCT_FULL;
      end
      return CSR_DATA_W'(int'($urandom_range(0, 2 * PERCENT)) - PERCENT);
   endfunction

   task automatic apply_random_settings();
      logic [CSR_DATA_W-1:0] thr;
      logic [CSR_DATA_W-1:0] ctl;
      thr = ($urandom_range(0, 7) == 0) ? CSR_DATA_W'($urandom_range(PERCENT + 1, 127))
                                         : CSR_DATA_W'($urandom_range(0, PERCENT));
      ctl = CSR_DATA_W'($urandom_range(0, 7));
      if ($urandom_range(0, 3) != 0) begin
         ctl[CTL_ENABLE] = 1'b1;
      end
      apply_settings(random_percent(1'b0), random_percent(1'b0), random_percent(1'b0),
                     random_percent(1'b1), random_percent(1'b1), random_percent(1'b1),
                     thr, ctl);
   endtask

   // ---------------------------------------------------------------- tests

   // registers as they come out of reset: channel disabled
   task automatic test_reset_defaults();
      weight_pct    = '{PCT_FULL, '0, '0};
      offset_pct    = '{'0, '0, '0};
      threshold_pct = 50;
      control_bits  = CTL_W'(MODE_OFF);
      send_request(make_request(FULL_SCALE, 1, FULL_SCALE, 1, FULL_SCALE, 1));
      send_request(make_request(-FULL_SCALE, 1, 0, 0, 0, 0));
      send_request(make_request(0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_add_mode();
      apply_settings(PCT_FULL, PCT_FULL, PCT_FULL, 0, 0, 0, 50, MODE_ADD);
      send_request(make_request(FULL_SCALE, 1, FULL_SCALE, 1, FULL_SCALE, 1));
      send_request(make_request(-FULL_SCALE, 1, -FULL_SCALE, 1, -FULL_SCALE, 1));
      send_request(make_request(-32768, 1, 32767, 1, 0, 1));
      send_request(make_request(8192, 1, 0, 0, 0, 0));      // switch exactly at threshold
      send_request(make_request(FULL_SCALE, 0, -FULL_SCALE, 0, 5, 1));
      // half-unit terms round away from zero
      apply_settings(-PCT_FULL, 33, 1, PCT_FULL, -PCT_FULL, 0, 0, MODE_ADD);
      send_request(make_request(0, 0, 0, 0, 50, 1));
      send_request(make_request(0, 0, 0, 0, -50, 1));
      send_request(make_request(100, 1, 3, 1, -150, 1));
   endtask

   task automatic test_multiply_mode();
      apply_settings(PCT_FULL, PCT_FULL, PCT_FULL, 0, 0, 0, 50, MODE_MUL);
      send_request(make_request(FULL_SCALE, 0, FULL_SCALE, 0, FULL_SCALE, 0)); // no active term
      send_request(make_request(0, 0, 8192, 1, 0, 0));
      send_request(make_request(8192, 1, 8192, 1, 8192, 1));
      send_request(make_request(-FULL_SCALE, 1, FULL_SCALE, 1, -32768, 1));
      // offsets make absent sources active
      apply_settings(PCT_FULL, PCT_FULL, -PCT_FULL, 0, 50, -1, 50, MODE_MUL | INVERT_BIT);
      send_request(make_request(0, 0, 0, 0, 0, 0));
      send_request(make_request(FULL_SCALE, 1, 0, 0, FULL_SCALE, 1));
   endtask

   task automatic test_invert_and_switch();
      apply_settings(PCT_FULL, 0, 0, 0, 0, 0, PCT_FULL, MODE_ADD | INVERT_BIT);
      send_request(make_request(FULL_SCALE, 1, 0, 0, 0, 0));
      send_request(make_request(FULL_SCALE - 1, 1, 0, 0, 0, 0));
      // threshold above full scale saturates to full scale
      apply_settings(PCT_FULL, 0, 0, 0, 0, 0, 127, MODE_ADD);
      send_request(make_request(FULL_SCALE, 1, 0, 0, 0, 0));
      send_request(make_request(1 - FULL_SCALE, 1, 0, 0, 0, 0));
      // disabled with zero threshold still turns the switch on
      apply_settings(PCT_FULL, 0, 0, 0, 0, 0, 0, MODE_OFF);
      send_request(make_request(FULL_SCALE, 1, 0, 0, 0, 0));
   endtask

   task automatic test_out_of_range_settings();
      apply_settings(-128, 127, 0, 127, -128, 0, 50, MODE_ADD);
      send_request(make_request(FULL_SCALE, 1, FULL_SCALE, 1, 0, 0));
      send_request(make_request(8192, 1, 0, 1, 0, 0));
   endtask

   // hold the result side while requests keep coming so the pipeline backs up
   task automatic test_backpressure();
      apply_random_settings();
      sender_idling    = 1'b0;
      receiver_idling  = 1'b0;
      hold_off_request = 1'b1;
      repeat (40) send_request(random_request());
   endtask

   task automatic test_random_mixing();
      int phase;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_random_settings();
         if (phase == RANDOM_PHASES - 1) begin
            sender_idling   = 1'b0;
            receiver_idling = 1'b0;
         end else begin
            sender_idling   = $urandom_range(0, 3) != 0;
            receiver_idling = $urandom_range(0, 3) != 0;
         end
         repeat (PHASE_ITEMS) send_request(random_request());
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_WEIGHT_A;
      csr_data  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_add_mode();
      test_multiply_mode();
      test_invert_and_switch();
      test_out_of_range_settings();
      test_backpressure();
      test_random_mixing();

      req_valid <= 1'b0;
      wait_drained();
      repeat (2 * PIPE_LATENCY) @(negedge clock);

      $display("Run covered %0d requests and %0d results over %0d register settings",
               request_count, result_count, setting_count);
      $display("Modes exercised: disabled, add, multiply, inverted; mismatches: %0d",
               error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
